[rtl/core/hkrst_pkg.sv]
// Package for the HID key report slot table: widths, opcodes, control types.
`default_nettype none

package hkrst_pkg;

  // Field widths fixed by the report format
  localparam int unsigned KeyW      = 8;
  localparam int unsigned ModW      = 8;
  localparam int unsigned CntW      = 8;
  localparam int unsigned IdxOutW   = 3;
  localparam int unsigned OpW       = 2;
  localparam int unsigned InDataW   = 24;
  localparam int unsigned OutDataW  = 16;

  // Defaults
  localparam int unsigned SlotsDefault = 6;
  localparam logic [CntW-1:0] AutoRelReset = 8'd15;

  // Item opcodes; code three means nothing and is dropped
  typedef enum logic [OpW-1:0] {
    OP_PRESS   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_BUILD   = 2'd2
  } opcode_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_item;
    logic edit;
    logic emit_beat;
    logic tick;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic out_free;
    logic last_slot;
  } stat_t;

endpackage

`default_nettype wire

[rtl/core/hid_key_report_slot_table.sv]
// Top level of the HID boot keyboard key report slot table.
//
//  channel  dir  handshake                     content
//  s_axis   in   s_axis_tvalid_i/tready_o      press, release or build item
//  m_axis   out  m_axis_tvalid_o/tready_i      one beat per slot of a report
//  cfg      in   cfg_valid_i/cfg_ready_o       self-release countdown value
//
// Press and release run: accept, then one table update.
// A build runs: accept, one beat per slot through the
// output register, then one countdown tick over all slots in parallel.
// Output stalls hold the slot walk; a new item is taken while the last beat
// still waits. Reset empties all slots and loads the countdown value 15.
`default_nettype none

module hid_key_report_slot_table
  import hkrst_pkg::*;
#(
  parameter int unsigned Slots = SlotsDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // key_code [7:0], modifier_bits [15:8], self_release [16], zero pad
  input  wire logic [InDataW-1:0]   s_axis_tdata_i,
  // opcode [1:0]
  input  wire logic [OpW-1:0]       s_axis_tuser_i,
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // slot_code [7:0], modifier_out [15:8]
  output logic [OutDataW-1:0]       m_axis_tdata_o,
  // slot_index [2:0]
  output logic [IdxOutW-1:0]        m_axis_tuser_o,
  output logic                      m_axis_tlast_o,
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  // countdown load value for self-released keys
  input  wire logic [CntW-1:0]      cfg_data_i,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o
);

  cmd_t            cmd;
  stat_t           stat;
  logic [KeyW-1:0] out_code;
  logic [ModW-1:0] out_mod;

  assign cfg_ready_o = 1'b1;

  hkrst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_opcode_i (s_axis_tuser_i),
    .in_ready_o  (s_axis_tready_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  hkrst_dp #(
    .Slots (Slots)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_opcode_i (s_axis_tuser_i),
    .in_key_i    (s_axis_tdata_i[7:0]),
    .in_mod_i    (s_axis_tdata_i[15:8]),
    .in_auto_i   (s_axis_tdata_i[16]),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_index_o (m_axis_tuser_o),
    .out_code_o  (out_code),
    .out_mod_o   (out_mod),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {out_mod, out_code};

endmodule

`default_nettype wire

[rtl/core/hkrst_ctrl.sv]
// Controller state machine for the HID key report slot table.
`default_nettype none

module hkrst_ctrl
  import hkrst_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic [OpW-1:0] in_opcode_i,
  output logic                in_ready_o,
  input  wire stat_t          stat_i,
  output cmd_t                cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EDIT,
    ST_EMIT,
    ST_TICK
  } state_e;

  state_e state_q;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;

  // Command decode
  always_comb begin
    cmd_o           = '0;
    cmd_o.load_item = accept;
    case (state_q)
      ST_EDIT: cmd_o.edit      = 1'b1;
      ST_EMIT: cmd_o.emit_beat = stat_i.out_free;
      ST_TICK: cmd_o.tick      = 1'b1;
      default: ;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            case (in_opcode_i)
              OP_PRESS, OP_RELEASE: state_q <= ST_EDIT;
              OP_BUILD:             state_q <= ST_EMIT;
              default:              state_q <= ST_IDLE;
            endcase
          end
        end
        ST_EDIT: state_q <= ST_IDLE;
        ST_EMIT: begin
          if (stat_i.out_free && stat_i.last_slot) begin
            state_q <= ST_TICK;
          end
        end
        ST_TICK: state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/core/hkrst_dp.sv]
// Datapath: slot table, countdowns, modifier, config register, output beat.
`default_nettype none

module hkrst_dp
  import hkrst_pkg::*;
#(
  parameter int unsigned Slots = SlotsDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cmd_t                cmd_i,
  output stat_t                    stat_o,
  // item fields
  input  wire logic [OpW-1:0]      in_opcode_i,
  input  wire logic [KeyW-1:0]     in_key_i,
  input  wire logic [ModW-1:0]     in_mod_i,
  input  wire logic                in_auto_i,
  // config
  input  wire logic                cfg_we_i,
  input  wire logic [CntW-1:0]     cfg_data_i,
  // result beat
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [IdxOutW-1:0]       out_index_o,
  output logic [KeyW-1:0]          out_code_o,
  output logic [ModW-1:0]          out_mod_o,
  output logic                     out_last_o
);

  localparam int unsigned IdxW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Slots - 1);

  logic [KeyW-1:0]  codes_q [Slots];
  logic [CntW-1:0]  cnt_q   [Slots];
  logic [ModW-1:0]  mod_q;
  logic [CntW-1:0]  auto_rel_q;
  logic [IdxW-1:0]  idx_q;

  logic [OpW-1:0]   op_q;
  logic [KeyW-1:0]  key_q;
  logic [ModW-1:0]  imod_q;
  logic             iauto_q;

  logic             out_valid_q;
  logic [IdxOutW-1:0] out_index_q;
  logic [KeyW-1:0]  out_code_q;
  logic [ModW-1:0]  out_mod_q;
  logic             out_last_q;

  logic [Slots-1:0] match;
  logic [Slots-1:0] empty;
  logic [Slots-1:0] first_empty;
  logic [Slots-1:0] expire;
  logic             seen_empty;
  logic [IdxW+IdxOutW-1:0] idx_ext;

  assign stat_o.out_free  = ~out_valid_q | out_ready_i;
  assign stat_o.last_slot = (idx_q == LastIdx);
  assign idx_ext          = {{IdxOutW{1'b0}}, idx_q};

  // Per-slot compares and first-empty pick
  always_comb begin
    seen_empty  = 1'b0;
    first_empty = '0;
    for (int i = 0; i < Slots; i++) begin
      match[i]       = (codes_q[i] == key_q);
      empty[i]       = (codes_q[i] == '0);
      first_empty[i] = empty[i] & ~seen_empty;
      seen_empty     = seen_empty | empty[i];
      // a countdown at one or two ends at this tick
      expire[i]      = (cnt_q[i] == CntW'(1)) || (cnt_q[i] == CntW'(2));
    end
  end

  // Latched item
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q    <= in_opcode_i;
      key_q   <= in_key_i;
      imod_q  <= in_mod_i;
      iauto_q <= in_auto_i;
    end
  end

  // Config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auto_rel_q <= AutoRelReset;
    end else if (cfg_we_i) begin
      auto_rel_q <= cfg_data_i;
    end
  end

  // Slot table, countdowns, modifier
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Slots; i++) begin
        codes_q[i] <= '0;
        cnt_q[i]   <= '0;
      end
      mod_q <= '0;
    end else if (cmd_i.edit && key_q != '0) begin
      case (op_q)
        OP_PRESS: begin
          if (match == '0 && seen_empty) begin
            for (int i = 0; i < Slots; i++) begin
              if (first_empty[i]) begin
                codes_q[i] <= key_q;
                cnt_q[i]   <= iauto_q ? auto_rel_q : '0;
              end
            end
            mod_q <= imod_q;
          end
        end
        OP_RELEASE: begin
          for (int i = 0; i < Slots; i++) begin
            if (match[i]) begin
              codes_q[i] <= '0;
              cnt_q[i]   <= '0;
            end
          end
          if (match != '0) begin
            mod_q <= '0;
          end
        end
        default: ;
      endcase
    end else if (cmd_i.tick) begin
      for (int i = 0; i < Slots; i++) begin
        if (expire[i]) begin
          codes_q[i] <= '0;
          cnt_q[i]   <= '0;
        end else if (cnt_q[i] > CntW'(2)) begin
          cnt_q[i] <= cnt_q[i] - CntW'(1);
        end
      end
      if (expire != '0) begin
        mod_q <= '0;
      end
    end
  end

  // Slot walk counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.emit_beat) begin
      idx_q <= stat_o.last_slot ? '0 : idx_q + IdxW'(1);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_beat) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_beat) begin
      out_index_q <= idx_ext[IdxOutW-1:0];
      out_code_q  <= codes_q[idx_q];
      out_mod_q   <= mod_q;
      out_last_q  <= stat_o.last_slot;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_index_o = out_index_q;
  assign out_code_o  = out_code_q;
  assign out_mod_o   = out_mod_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire
